### rtl/per_node_tx_slot_table_core_assert.svh
// Assertion macros for the per-node transmit slot table.
`ifndef PER_NODE_TX_SLOT_TABLE_CORE_ASSERT_SVH
`define PER_NODE_TX_SLOT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTST_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("%m: check failed");
`define PTST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`else
`define PTST_ASSERT(lbl, cond)
`define PTST_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/ptst_pkg.sv
// Shared constants for the per-node transmit slot table.
package ptst_pkg;

    localparam int DEF_NODE_ENTRIES   = 16;
    localparam int DEF_SLOTS_PER_NODE = 4;

    localparam int ADDR_W = 16;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int THR_W  = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_ENT_W   = 4;
    localparam int OUT_SLOT_W  = 2;
    localparam int OUT_USED_W  = 7;

    localparam logic [THR_W-1:0] THR_RESET = 5'd10;

    localparam logic [ADDR_W-1:0] ADDR_RSVD_LO = 16'h0000;
    localparam logic [ADDR_W-1:0] ADDR_RSVD_HI = 16'hFFFF;

    localparam logic [OP_W-1:0] OP_WR_UNI = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_GRP = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_ENTRY  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_RESERVED  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

endpackage

### rtl/per_node_tx_slot_table_core.sv
// Per-node transmit slot table: address match array, slot map memory and sequencer.
// Write, free, modify: accept, lookup, then map memory read-modify-write with the result
// registered at that edge; a request rejected at lookup gets its result from the lookup.
// Drain: accept and lookup, then per entry visited a read state and an emit state that
// emits the entry's slots one per cycle; a stalled output holds the sequencer.
// Reset (synchronous, active low) clears valid bits, counters, the sequencer and the
// output valid flag; the map memory is not swept, invalid entries' contents go unused.
module per_node_tx_slot_table_core
    import ptst_pkg::*;
#(
    parameter int NODE_ENTRIES   = DEF_NODE_ENTRIES,
    parameter int SLOTS_PER_NODE = DEF_SLOTS_PER_NODE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // operation[2:0], node_addr[18:3], new_addr[34:19], zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[2:0], entry_index[6:3], slot_index[8:7], out_node_addr[24:9],
    // slots_in_use[31:25], group_ready[32], zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [THR_W-1:0]       i_cfg_data
);

    localparam int ENT_W  = $clog2(NODE_ENTRIES);
    localparam int SLOT_W = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
    localparam int FREE_W = $clog2(NODE_ENTRIES + 1);
    localparam int USED_W = $clog2(NODE_ENTRIES * SLOTS_PER_NODE + 1);
    localparam int PC_W   = $clog2(SLOTS_PER_NODE + 1);
    localparam int CMP_W  = (FREE_W > THR_W) ? FREE_W : THR_W;
    localparam int MEM_W  = ADDR_W + SLOTS_PER_NODE;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_RD    = 5'b00100,
        S_DRD   = 5'b01000,
        S_DEMIT = 5'b10000
    } t_state;

    function automatic logic [ENT_W-1:0] first_ent(input logic [NODE_ENTRIES-1:0] v);
        logic [ENT_W-1:0] idx;
        idx = '0;
        for (int i = NODE_ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) idx = ENT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] first_slot(input logic [SLOTS_PER_NODE-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS_PER_NODE - 1; i >= 0; i--) begin
            if (v[i]) idx = SLOT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [PC_W-1:0] pop_slots(input logic [SLOTS_PER_NODE-1:0] v);
        logic [PC_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < SLOTS_PER_NODE; i++) begin
            cnt = cnt + PC_W'(v[i]);
        end
        return cnt;
    endfunction

    function automatic logic is_rsvd(input logic [ADDR_W-1:0] a);
        return (a == ADDR_RSVD_LO) || (a == ADDR_RSVD_HI);
    endfunction

    t_state                     r_state, n_state;
    logic [NODE_ENTRIES-1:0]    r_valid, n_valid;
    logic [FREE_W-1:0]          r_free, n_free;
    logic [USED_W-1:0]          r_used, n_used;
    logic [ENT_W-1:0]           r_e, n_e;
    logic                       r_fresh, n_fresh;
    logic                       r_first, n_first;
    logic [SLOTS_PER_NODE-1:0]  r_map, n_map;
    logic [THR_W-1:0]           r_thr;

    logic [OP_W-1:0]            r_op;
    logic [ADDR_W-1:0]          r_addr;
    logic [ADDR_W-1:0]          r_new;
    logic [NODE_ENTRIES-1:0]    r_hit;

    logic [ADDR_W-1:0]          r_cam [NODE_ENTRIES];
    logic [MEM_W-1:0]           r_mem [NODE_ENTRIES];
    logic [MEM_W-1:0]           r_q;

    logic                       r_ovalid;
    logic [OUT_TDATA_W-1:0]     r_odata;
    logic                       r_olast;

    logic                       s_accept;
    logic                       out_free;
    logic                       commit;
    logic                       cam_we;
    logic [ENT_W-1:0]           cam_idx;
    logic [ADDR_W-1:0]          cam_data;
    logic                       mem_we;
    logic [ENT_W-1:0]           mem_wa;
    logic [MEM_W-1:0]           mem_wd;
    logic                       rd_en;
    logic [ENT_W-1:0]           rd_a;

    logic                       res_v;
    logic [ST_W-1:0]            res_st;
    logic [ENT_W-1:0]           res_e;
    logic [SLOT_W-1:0]          res_s;
    logic [ADDR_W-1:0]          res_addr;
    logic                       res_last;
    logic [FREE_W-1:0]          res_free;
    logic                       res_gr;

    logic [ADDR_W-1:0]          in_addr;
    logic [ADDR_W-1:0]          q_addr;
    logic [SLOTS_PER_NODE-1:0]  q_map;
    logic [SLOTS_PER_NODE-1:0]  cur_map;
    logic [SLOTS_PER_NODE-1:0]  slot_bit;
    logic [SLOTS_PER_NODE-1:0]  open_slots;
    logic                       hit_any;
    logic [ENT_W-1:0]           hit_idx;
    logic                       free_any;
    logic [ENT_W-1:0]           free_idx;
    logic [PC_W-1:0]            pc;

    logic [ENT_W+OUT_ENT_W-1:0]   ent_ext;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;
    logic [USED_W+OUT_USED_W-1:0] used_ext;

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign in_addr     = i_s_tdata[18:3];

    assign q_addr   = r_q[MEM_W-1:SLOTS_PER_NODE];
    assign q_map    = r_q[SLOTS_PER_NODE-1:0];
    assign hit_any  = |r_hit;
    assign hit_idx  = first_ent(r_hit);
    assign free_any = |(~r_valid);
    assign free_idx = first_ent(~r_valid);
    assign out_free = !r_ovalid || i_m_tready;
    assign commit   = !res_v || out_free;

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_free   = r_free;
        n_used   = r_used;
        n_e      = r_e;
        n_fresh  = r_fresh;
        n_first  = r_first;
        n_map    = r_map;
        cam_we   = 1'b0;
        cam_idx  = r_e;
        cam_data = r_addr;
        mem_we   = 1'b0;
        mem_wa   = r_e;
        mem_wd   = '0;
        rd_en    = 1'b0;
        rd_a     = r_e;
        res_v    = 1'b0;
        res_st   = ST_OK;
        res_e    = '0;
        res_s    = '0;
        res_addr = '0;
        res_last = 1'b1;
        cur_map  = r_first ? q_map : r_map;
        open_slots = r_fresh ? {SLOTS_PER_NODE{1'b1}} : ~q_map;
        slot_bit = '0;
        pc       = pop_slots(q_map);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_LOOK;
            end
            S_LOOK: begin
                case (r_op)
                    OP_WR_UNI, OP_WR_GRP: begin
                        if (hit_any) begin
                            rd_en   = 1'b1;
                            rd_a    = hit_idx;
                            n_e     = hit_idx;
                            n_fresh = 1'b0;
                            n_state = S_RD;
                        end else if (free_any) begin
                            // claimed entry starts with an empty map, no read needed
                            n_valid[free_idx] = 1'b1;
                            n_free   = FREE_W'(r_free - 1'b1);
                            cam_we   = 1'b1;
                            cam_idx  = free_idx;
                            n_e      = free_idx;
                            n_fresh  = 1'b1;
                            n_state  = S_RD;
                        end else begin
                            res_v   = 1'b1;
                            res_st  = ST_NO_ENTRY;
                            n_state = S_IDLE;
                        end
                    end
                    OP_FREE: begin
                        if (is_rsvd(r_addr)) begin
                            res_v   = 1'b1;
                            res_st  = ST_RESERVED;
                            n_state = S_IDLE;
                        end else if (!hit_any) begin
                            res_v   = 1'b1;
                            res_st  = ST_NOT_FOUND;
                            n_state = S_IDLE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_a    = hit_idx;
                            n_e     = hit_idx;
                            n_fresh = 1'b0;
                            n_state = S_RD;
                        end
                    end
                    OP_MODIFY: begin
                        if (is_rsvd(r_addr) || is_rsvd(r_new)) begin
                            res_v   = 1'b1;
                            res_st  = ST_RESERVED;
                            n_state = S_IDLE;
                        end else if (!hit_any) begin
                            res_v   = 1'b1;
                            res_st  = ST_NOT_FOUND;
                            n_state = S_IDLE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_a    = hit_idx;
                            n_e     = hit_idx;
                            n_fresh = 1'b0;
                            n_state = S_RD;
                        end
                    end
                    OP_DRAIN: begin
                        if (r_used == '0) begin
                            res_v   = 1'b1;
                            res_st  = ST_EMPTY;
                            n_state = S_IDLE;
                        end else begin
                            n_e     = '0;
                            n_state = S_DRD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                n_state = S_IDLE;
                res_v   = 1'b1;
                case (r_op)
                    OP_WR_UNI, OP_WR_GRP: begin
                        if (|open_slots) begin
                            res_s    = first_slot(open_slots);
                            slot_bit[res_s] = 1'b1;
                            mem_we   = 1'b1;
                            mem_wd   = {r_addr, (r_fresh ? '0 : q_map) | slot_bit};
                            n_used   = USED_W'(r_used + 1'b1);
                            res_e    = r_e;
                        end else if (r_op == OP_WR_UNI && free_any) begin
                            // node full: open a second entry with the same address
                            n_valid[free_idx] = 1'b1;
                            n_free   = FREE_W'(r_free - 1'b1);
                            cam_we   = 1'b1;
                            cam_idx  = free_idx;
                            slot_bit[0] = 1'b1;
                            mem_we   = 1'b1;
                            mem_wa   = free_idx;
                            mem_wd   = {r_addr, slot_bit};
                            n_used   = USED_W'(r_used + 1'b1);
                            res_e    = free_idx;
                        end else if (r_op == OP_WR_UNI) begin
                            res_st   = ST_NO_ENTRY;
                        end else begin
                            res_st   = ST_FULL;
                            res_e    = r_e;
                        end
                    end
                    OP_FREE: begin
                        n_valid[r_e] = 1'b0;
                        n_free = FREE_W'(r_free + 1'b1);
                        n_used = (r_used >= USED_W'(pc)) ? USED_W'(r_used - USED_W'(pc)) : '0;
                        res_e  = r_e;
                    end
                    OP_MODIFY: begin
                        cam_we   = 1'b1;
                        cam_data = r_new;
                        mem_we   = 1'b1;
                        mem_wd   = {r_new, q_map};
                        res_e    = r_e;
                    end
                    default: begin
                        res_v = 1'b0;
                    end
                endcase
            end
            S_DRD: begin
                rd_en   = 1'b1;
                n_first = 1'b1;
                n_state = S_DEMIT;
            end
            S_DEMIT: begin
                if (!r_valid[r_e] || cur_map == '0) begin
                    if (r_valid[r_e]) begin
                        n_valid[r_e] = 1'b0;
                        n_free = FREE_W'(r_free + 1'b1);
                    end
                    n_e     = ENT_W'(r_e + 1'b1);
                    n_state = S_DRD;
                end else begin
                    res_v    = 1'b1;
                    res_e    = r_e;
                    res_s    = first_slot(cur_map);
                    res_addr = q_addr;
                    slot_bit[res_s] = 1'b1;
                    n_map    = cur_map & ~slot_bit;
                    n_first  = 1'b0;
                    n_used   = USED_W'(r_used - 1'b1);
                    res_last = (r_used == USED_W'(1));
                    if (res_last) begin
                        // every remaining entry is released with the final slot
                        n_valid = '0;
                        n_free  = FREE_W'(NODE_ENTRIES);
                        n_state = S_IDLE;
                    end else if (n_map == '0) begin
                        n_valid[r_e] = 1'b0;
                        n_free  = FREE_W'(r_free + 1'b1);
                        n_e     = ENT_W'(r_e + 1'b1);
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // drain results report free entries before the entry is released
        res_free = (r_state == S_DEMIT) ? r_free : n_free;
        res_gr   = (CMP_W'(res_free) >= CMP_W'(r_thr));
        ent_ext  = {{OUT_ENT_W{1'b0}}, res_e};
        slot_ext = {{OUT_SLOT_W{1'b0}}, res_s};
        used_ext = {{OUT_USED_W{1'b0}}, n_used};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_free   <= FREE_W'(NODE_ENTRIES);
            r_used   <= '0;
            r_e      <= '0;
            r_fresh  <= 1'b0;
            r_first  <= 1'b0;
            r_map    <= '0;
            r_thr    <= THR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (commit) begin
                r_state <= n_state;
                r_valid <= n_valid;
                r_free  <= n_free;
                r_used  <= n_used;
                r_e     <= n_e;
                r_fresh <= n_fresh;
                r_first <= n_first;
                r_map   <= n_map;
            end
            if (res_v && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op   <= i_s_tdata[2:0];
            r_addr <= in_addr;
            r_new  <= i_s_tdata[34:19];
            for (int i = 0; i < NODE_ENTRIES; i++) begin
                r_hit[i] <= r_valid[i] && (r_cam[i] == in_addr);
            end
        end
        if (res_v && out_free) begin
            r_odata <= {7'b0, res_gr, used_ext[OUT_USED_W-1:0], res_addr,
                        slot_ext[OUT_SLOT_W-1:0], ent_ext[OUT_ENT_W-1:0], res_st};
            r_olast <= res_last;
        end
    end

    // address match array
    always_ff @(posedge i_clk) begin
        if (cam_we && commit) r_cam[cam_idx] <= cam_data;
    end

    // slot map memory: {address, slot map} per entry, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we && commit) r_mem[mem_wa] <= mem_wd;
        if (rd_en) r_q <= r_mem[rd_a];
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

`include "per_node_tx_slot_table_core_assert.svh"

    `PTST_ASSERT(a_free_count, r_free == FREE_W'($countones(~r_valid)))
    `PTST_ASSERT(a_used_bound, r_used <= USED_W'(NODE_ENTRIES * SLOTS_PER_NODE))
    `PTST_ASSERT_IMP(a_drain_has_slots, (r_state == S_DRD) || (r_state == S_DEMIT), r_used != '0)

endmodule
